@@ rtl/skmr_pkg.sv @@
// shared types and constants of the sorted k-mer run filter
`timescale 1ns / 1ps
`default_nettype none

package skmr_pkg;

  localparam int HASH_W  = 64;
  localparam int POS_W   = 40;
  localparam int LEN_W   = 6;
  localparam int CFG_W   = 6;
  localparam int KIND_W  = 2;

  localparam logic [CFG_W-1:0] MAX_OCC_RST = 6'd32;

  // result kinds on the output channel
  localparam logic [KIND_W-1:0] RES_POS   = 2'd0;
  localparam logic [KIND_W-1:0] RES_ENTRY = 2'd1;
  localparam logic [KIND_W-1:0] RES_END   = 2'd2;

  // command queue between front and back
  localparam int QDEPTH  = 4;
  localparam int Q_PTR_W = $clog2(QDEPTH);
  localparam int Q_CNT_W = $clog2(QDEPTH + 1);
  localparam int N_PUSH  = 3;

  typedef enum logic {
    CMD_RUN,
    CMD_END
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [HASH_W-1:0]  hash;
    logic [LEN_W-1:0]   count;
    logic               bank;
    logic               last_res;
  } cmd_t;

  // back part hands a buffer bank back to the front
  typedef struct packed {
    logic done;
    logic bank;
  } bank_rel_t;

endpackage

`default_nettype wire

@@ rtl/skmr_posbuf.sv @@
// two-bank position buffer, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module skmr_posbuf
  import skmr_pkg::*;
#(
  parameter int ADDR_W = 6
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [POS_W-1:0]  wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [POS_W-1:0]  rd_data_o
);

  logic [POS_W-1:0] mem_q [2**ADDR_W];
  logic [POS_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

@@ rtl/skmr_cmdq.sv @@
// short command queue between front and back, up to three pushes per cycle
`timescale 1ns / 1ps
`default_nettype none

module skmr_cmdq
  import skmr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [N_PUSH-1:0] push_i,
  input  wire cmd_t [N_PUSH-1:0] push_cmd_i,
  output logic                   room_o,
  output logic                   head_valid_o,
  output cmd_t                   head_o,
  input  wire logic              pop_i
);

  cmd_t               q_q [QDEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic [Q_PTR_W-1:0] addr0, addr1, addr2;
  logic [Q_CNT_W-1:0] n_push;

  // pushes are packed in order onto consecutive slots
  assign addr0  = wr_ptr_q;
  assign addr1  = addr0 + Q_PTR_W'(push_i[0]);
  assign addr2  = addr1 + Q_PTR_W'(push_i[1]);
  assign n_push = Q_CNT_W'(push_i[0]) + Q_CNT_W'(push_i[1]) + Q_CNT_W'(push_i[2]);

  assign wr_ptr_d = addr2 + Q_PTR_W'(push_i[2]);
  assign rd_ptr_d = rd_ptr_q + Q_PTR_W'(pop_i);
  assign cnt_d    = cnt_q + n_push - Q_CNT_W'(pop_i);

  always_ff @(posedge clk_i) begin
    if (push_i[0]) begin
      q_q[addr0] <= push_cmd_i[0];
    end
    if (push_i[1]) begin
      q_q[addr1] <= push_cmd_i[1];
    end
    if (push_i[2]) begin
      q_q[addr2] <= push_cmd_i[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign room_o       = cnt_q <= Q_CNT_W'(QDEPTH - N_PUSH);
  assign head_valid_o = cnt_q != '0;
  assign head_o       = q_q[rd_ptr_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i != '0) |-> ({1'b0, cnt_q} + {1'b0, n_push}) <= (Q_CNT_W + 1)'(QDEPTH))
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("command queue pop while empty");

endmodule

`default_nettype wire

@@ rtl/skmr_front.sv @@
// front part: run tracking, keep decision, buffer writes and command pushes
`timescale 1ns / 1ps
`default_nettype none

module skmr_front
  import skmr_pkg::*;
#(
  parameter int MAX_RUN       = 32,
  parameter int POSITION_BITS = 40,
  parameter int ADDR_W        = 6
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  input  wire logic [CFG_W-1:0]  cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [HASH_W-1:0] kmer_hash_i,
  input  wire logic [POS_W-1:0]  kmer_position_i,
  input  wire logic              end_of_stream_i,
  input  wire logic              q_room_i,
  output logic [N_PUSH-1:0]      push_o,
  output cmd_t [N_PUSH-1:0]      push_cmd_o,
  input  wire bank_rel_t         rel_i,
  output logic                   wr_en_o,
  output logic [ADDR_W-1:0]      wr_addr_o,
  output logic [POS_W-1:0]       wr_data_o
);

  localparam int IDX_W = ADDR_W - 1;
  localparam int CNT_W = $clog2(MAX_RUN + 2);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam logic [CNT_W-1:0] MaxRunC = CNT_W'(MAX_RUN);
  localparam logic [POS_W-1:0] PosMask = (POSITION_BITS >= POS_W) ? {POS_W{1'b1}} :
                                         ((POS_W'(1) << POSITION_BITS) - POS_W'(1));

  logic [CFG_W-1:0]  max_occ_q;
  logic              run_active_q, run_active_d;
  logic [HASH_W-1:0] cur_hash_q, cur_hash_d;
  logic [CNT_W-1:0]  run_count_q, run_count_d;
  logic              wbank_q, wbank_d;
  logic [1:0]        busy_q, busy_d;

  logic              diff, keep_prev, new_run, tgt_bank, keep_cur, accept;
  logic [CNT_W-1:0]  cnt_base, cnt_next;

  function automatic logic keeps(input logic [CNT_W-1:0] cnt, input logic [CFG_W-1:0] lim);
    keeps = (CMP_W'(cnt) <= CMP_W'(lim)) && (cnt <= MaxRunC);
  endfunction

  always_comb begin
    diff      = run_active_q && (kmer_hash_i != cur_hash_q);
    keep_prev = diff && keeps(run_count_q, max_occ_q);
    new_run   = !run_active_q || diff;
    // a kept run leaves its bank to the back, the new run takes the other one
    tgt_bank  = keep_prev ? ~wbank_q : wbank_q;
    cnt_base  = new_run ? '0 : run_count_q;
    cnt_next  = (cnt_base <= MaxRunC) ? cnt_base + CNT_W'(1) : cnt_base;
    keep_cur  = keeps(cnt_next, max_occ_q);

    in_ready_o = q_room_i && !busy_q[tgt_bank];
    accept     = in_valid_i && in_ready_o;

    push_o[0]                = accept && keep_prev;
    push_cmd_o[0].kind       = CMD_RUN;
    push_cmd_o[0].hash       = cur_hash_q;
    push_cmd_o[0].count      = LEN_W'(run_count_q);
    push_cmd_o[0].bank       = wbank_q;
    push_cmd_o[0].last_res   = !end_of_stream_i;

    push_o[1]                = accept && end_of_stream_i && keep_cur;
    push_cmd_o[1].kind       = CMD_RUN;
    push_cmd_o[1].hash       = kmer_hash_i;
    push_cmd_o[1].count      = LEN_W'(cnt_next);
    push_cmd_o[1].bank       = tgt_bank;
    push_cmd_o[1].last_res   = 1'b0;

    push_o[2]                = accept && end_of_stream_i;
    push_cmd_o[2].kind       = CMD_END;
    push_cmd_o[2].hash       = '0;
    push_cmd_o[2].count      = '0;
    push_cmd_o[2].bank       = 1'b0;
    push_cmd_o[2].last_res   = 1'b1;

    wr_en_o   = accept && (cnt_base < MaxRunC);
    wr_addr_o = {tgt_bank, cnt_base[IDX_W-1:0]};
    wr_data_o = kmer_position_i & PosMask;

    run_active_d = run_active_q;
    cur_hash_d   = cur_hash_q;
    run_count_d  = run_count_q;
    wbank_d      = wbank_q;
    if (accept) begin
      if (end_of_stream_i) begin
        run_active_d = 1'b0;
        cur_hash_d   = '0;
        run_count_d  = '0;
        wbank_d      = keep_cur ? ~tgt_bank : tgt_bank;
      end else begin
        run_active_d = 1'b1;
        cur_hash_d   = kmer_hash_i;
        run_count_d  = cnt_next;
        wbank_d      = tgt_bank;
      end
    end

    busy_d = busy_q;
    if (rel_i.done) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (push_o[0]) begin
      busy_d[wbank_q] = 1'b1;
    end
    if (push_o[1]) begin
      busy_d[tgt_bank] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_occ_q    <= MAX_OCC_RST;
      run_active_q <= 1'b0;
      cur_hash_q   <= '0;
      run_count_q  <= '0;
      wbank_q      <= 1'b0;
      busy_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        max_occ_q <= cfg_data_i;
      end
      run_active_q <= run_active_d;
      cur_hash_q   <= cur_hash_d;
      run_count_q  <= run_count_d;
      wbank_q      <= wbank_d;
      busy_q       <= busy_d;
    end
  end

  a_close_bank_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o[0] |-> !busy_q[wbank_q])
    else $error("closing run found its bank still in use");

  a_open_bank_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_active_q |-> !busy_q[wbank_q])
    else $error("open run shares a bank with the back part");

endmodule

`default_nettype wire

@@ rtl/skmr_back.sv @@
// back part: replays kept runs from the buffer and drives the result register
`timescale 1ns / 1ps
`default_nettype none

module skmr_back
  import skmr_pkg::*;
#(
  parameter int ADDR_W = 6
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  input  wire cmd_t              cmd_i,
  output logic                   cmd_pop_o,
  output bank_rel_t              rel_o,
  output logic                   rd_en_o,
  output logic [ADDR_W-1:0]      rd_addr_o,
  input  wire logic [POS_W-1:0]  rd_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [KIND_W-1:0]      result_kind_o,
  output logic [HASH_W-1:0]      entry_hash_o,
  output logic [POS_W-1:0]       entry_position_o,
  output logic [POS_W-1:0]       list_index_o,
  output logic [LEN_W-1:0]       run_length_o,
  output logic                   final_result_o
);

  localparam int IDX_W = ADDR_W - 1;
  localparam int LW1   = LEN_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_POS,
    ST_ENTRY
  } state_e;

  state_e            state_q;
  logic [IDX_W-1:0]  idx_q;
  logic [POS_W-1:0]  kept_q;
  logic [POS_W-1:0]  start_q;
  logic              out_valid_q;
  logic [KIND_W-1:0] kind_q;
  logic [HASH_W-1:0] hash_q;
  logic [POS_W-1:0]  pos_q;
  logic [POS_W-1:0]  index_q;
  logic [LEN_W-1:0]  len_q;
  logic              last_q;

  logic slot_free, last_pos;

  assign slot_free = !out_valid_q || out_ready_i;
  assign last_pos  = (LW1'(idx_q) + LW1'(1)) == LW1'(cmd_i.count);

  always_comb begin
    cmd_pop_o = 1'b0;
    rel_o     = '{done: 1'b0, bank: cmd_i.bank};
    unique case (state_q)
      ST_IDLE: begin
        cmd_pop_o = cmd_valid_i && (cmd_i.kind == CMD_END) && slot_free;
      end
      ST_ENTRY: begin
        cmd_pop_o  = slot_free;
        rel_o.done = slot_free;
      end
      default: begin
      end
    endcase
  end

  assign rd_en_o   = state_q == ST_READ;
  assign rd_addr_o = {cmd_i.bank, idx_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      kept_q      <= '0;
      start_q     <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= RES_POS;
      hash_q      <= '0;
      pos_q       <= '0;
      index_q     <= '0;
      len_q       <= '0;
      last_q      <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            if (cmd_i.kind == CMD_END) begin
              if (slot_free) begin
                out_valid_q <= 1'b1;
                kind_q      <= RES_END;
                hash_q      <= '0;
                pos_q       <= '0;
                index_q     <= kept_q;
                len_q       <= '0;
                last_q      <= cmd_i.last_res;
                kept_q      <= '0;
              end
            end else begin
              idx_q   <= '0;
              start_q <= kept_q;
              state_q <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state_q <= ST_POS;
        end
        ST_POS: begin
          // buffer data is held until the next read, so a stall is harmless
          if (slot_free) begin
            out_valid_q <= 1'b1;
            kind_q      <= RES_POS;
            hash_q      <= cmd_i.hash;
            pos_q       <= rd_data_i;
            index_q     <= kept_q;
            len_q       <= '0;
            last_q      <= 1'b0;
            kept_q      <= kept_q + POS_W'(1);
            if (last_pos) begin
              state_q <= ST_ENTRY;
            end else begin
              idx_q   <= idx_q + IDX_W'(1);
              state_q <= ST_READ;
            end
          end
        end
        ST_ENTRY: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            kind_q      <= RES_ENTRY;
            hash_q      <= cmd_i.hash;
            pos_q       <= '0;
            index_q     <= start_q;
            len_q       <= cmd_i.count;
            last_q      <= cmd_i.last_res;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = kind_q;
  assign entry_hash_o     = hash_q;
  assign entry_position_o = pos_q;
  assign list_index_o     = index_q;
  assign run_length_o     = len_q;
  assign final_result_o   = last_q;

endmodule

`default_nettype wire

@@ rtl/sorted_kmer_run_filter.sv @@
// top level of the sorted k-mer run filter
// Takes (hash, position) items sorted by hash and groups equal adjacent hashes into runs.
// A run of at most max_occurrences items (and at most MAX_RUN) is replayed as its positions,
// each with the next compacted-list index, then one table entry; longer runs vanish, and
// an end_of_stream item closes the open run and adds an end marker. The front part takes an
// input whenever the command queue has room for three commands and the buffer
// bank the item lands in is free; the position buffer has two banks, so one run can fill
// while the previous one drains. For each kept run the back part picks up the command, then
// for each kept position does a registered buffer read and then loads the output register,
// then loads the table entry; an end marker is loaded directly. No clearing pass is needed
// after reset.
`timescale 1ns / 1ps
`default_nettype none

module sorted_kmer_run_filter
  import skmr_pkg::*;
#(
  parameter int MAX_RUN       = 32,
  parameter int POSITION_BITS = 40
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [CFG_W-1:0]  cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [HASH_W-1:0] kmer_hash_i,
  input  wire logic [POS_W-1:0]  kmer_position_i,
  input  wire logic              end_of_stream_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [KIND_W-1:0]      result_kind_o,
  output logic [HASH_W-1:0]      entry_hash_o,
  output logic [POS_W-1:0]       entry_position_o,
  output logic [POS_W-1:0]       list_index_o,
  output logic [LEN_W-1:0]       run_length_o,
  output logic                   final_result_o
);

  localparam int IDX_W  = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
  localparam int ADDR_W = IDX_W + 1;

  logic                cfg_wr;
  logic                q_room;
  logic [N_PUSH-1:0]   push;
  cmd_t [N_PUSH-1:0]   push_cmd;
  logic                head_valid;
  cmd_t                head;
  logic                pop;
  bank_rel_t           rel;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [POS_W-1:0]    wr_data;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [POS_W-1:0]    rd_data;

  // register writes must land only while idle; this is not enforced, all writes are taken
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  skmr_front #(
    .MAX_RUN      (MAX_RUN),
    .POSITION_BITS(POSITION_BITS),
    .ADDR_W       (ADDR_W)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_wr),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kmer_hash_i    (kmer_hash_i),
    .kmer_position_i(kmer_position_i),
    .end_of_stream_i(end_of_stream_i),
    .q_room_i       (q_room),
    .push_o         (push),
    .push_cmd_o     (push_cmd),
    .rel_i          (rel),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data)
  );

  skmr_posbuf #(
    .ADDR_W(ADDR_W)
  ) u_posbuf (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  skmr_cmdq u_cmdq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_cmd_i  (push_cmd),
    .room_o      (q_room),
    .head_valid_o(head_valid),
    .head_o      (head),
    .pop_i       (pop)
  );

  skmr_back #(
    .ADDR_W(ADDR_W)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (head_valid),
    .cmd_i           (head),
    .cmd_pop_o       (pop),
    .rel_o           (rel),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .rd_data_i       (rd_data),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_kind_o   (result_kind_o),
    .entry_hash_o    (entry_hash_o),
    .entry_position_o(entry_position_o),
    .list_index_o    (list_index_o),
    .run_length_o    (run_length_o),
    .final_result_o  (final_result_o)
  );

endmodule

`default_nettype wire

@@ dv/sorted_kmer_run_filter_tb.sv @@
// self-checking testbench of the sorted k-mer run filter: directed table, then random runs
`timescale 1ns / 1ps

module sorted_kmer_run_filter_tb
  import skmr_pkg::*;
;

  localparam int MAX_RUN       = 32;
  localparam int ITEM_GOAL     = 470;
  localparam int DIRECTED_N    = 12;
  localparam int SETTLE_CYCLES = 20;
  localparam int DRAIN_CYCLES  = 50;
  localparam int QUIET_LIMIT   = 4000;
  localparam int REPORT_MAX    = 10;

  localparam logic [POS_W-1:0] POS_ONES = '1;

  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [POS_W-1:0]  pos;
    logic              eos;
    logic              typed;
    logic [KIND_W-1:0] t_kind;
    logic [POS_W-1:0]  t_index;
    logic [LEN_W-1:0]  t_len;
  } kmer_stim_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [HASH_W-1:0] hash;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  index;
    logic [LEN_W-1:0]  len;
    logic              fin;
  } list_entry_t;

  typedef enum int {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_e;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i  = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  kmer_stim_t       drv         = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;

  logic [KIND_W-1:0] result_kind_o;
  logic [HASH_W-1:0] entry_hash_o;
  logic [POS_W-1:0]  entry_position_o;
  logic [POS_W-1:0]  list_index_o;
  logic [LEN_W-1:0]  run_length_o;
  logic              final_result_o;

  sorted_kmer_run_filter #(
    .MAX_RUN       (MAX_RUN),
    .POSITION_BITS (POS_W)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kmer_hash_i      (drv.hash),
    .kmer_position_i  (drv.pos),
    .end_of_stream_i  (drv.eos),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_kind_o    (result_kind_o),
    .entry_hash_o     (entry_hash_o),
    .entry_position_o (entry_position_o),
    .list_index_o     (list_index_o),
    .run_length_o     (run_length_o),
    .final_result_o   (final_result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run tracker state, mirrors the block
  logic [CFG_W-1:0]  occ_limit   = MAX_OCC_RST;
  bit                run_open    = 1'b0;
  logic [HASH_W-1:0] run_hash    = '0;
  int                run_cnt     = 0;
  logic [POS_W-1:0]  run_positions [MAX_RUN];
  logic [POS_W-1:0]  kept_total  = '0;

  list_entry_t pending_entries[$];
  int          mismatch_count = 0;
  int          quiet_cycles   = 0;
  int          burst_left     = 0;

  function automatic list_entry_t mk_entry(input logic [KIND_W-1:0] kind,
                                           input logic [HASH_W-1:0] hash,
                                           input logic [POS_W-1:0] pos,
                                           input logic [POS_W-1:0] index,
                                           input logic [LEN_W-1:0] len);
    list_entry_t e;
    e.kind  = kind;
    e.hash  = hash;
    e.pos   = pos;
    e.index = index;
    e.len   = len;
    e.fin   = 1'b0;
    return e;
  endfunction

  task automatic close_kmer_run();
    logic [POS_W-1:0] start_idx;
    int i;
    start_idx = kept_total;
    if (run_open && run_cnt <= occ_limit && run_cnt <= MAX_RUN) begin
      for (i = 0; i < run_cnt; i++) begin
        pending_entries.push_back(mk_entry(RES_POS, run_hash, run_positions[i], kept_total, '0));
        kept_total = kept_total + 1'b1;
      end
      pending_entries.push_back(mk_entry(RES_ENTRY, run_hash, '0, start_idx, run_cnt[LEN_W-1:0]));
    end
    run_open = 1'b0;
    run_cnt  = 0;
  endtask

  task automatic fold_kmer(input logic [HASH_W-1:0] hash, input logic [POS_W-1:0] pos,
                           input logic eos);
    int n_before;
    list_entry_t e;
    n_before = pending_entries.size();
    if (run_open && hash != run_hash) close_kmer_run();
    if (!run_open) begin
      run_open = 1'b1;
      run_hash = hash;
      run_cnt  = 0;
    end
    if (run_cnt < MAX_RUN) run_positions[run_cnt] = pos;
    if (run_cnt <= MAX_RUN) run_cnt++;
    if (eos) begin
      close_kmer_run();
      pending_entries.push_back(mk_entry(RES_END, '0, '0, kept_total, '0));
      kept_total = '0;
      run_hash   = '0;
    end
    if (pending_entries.size() > n_before) begin
      e = pending_entries.pop_back();
      e.fin = 1'b1;
      pending_entries.push_back(e);
    end
  endtask

  task automatic report_entry(input string tag, input list_entry_t e);
    $display("  %s: kind %0d hash %h pos %h index %h len %0d last %0d",
             tag, e.kind, e.hash, e.pos, e.index, e.len, e.fin);
  endtask

  always @(posedge clk_i) begin : monitor
    int n_before;
    list_entry_t want;
    list_entry_t got;
    bit moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        occ_limit = cfg_data_i;
        moved = 1'b1;
      end
      if (in_valid_i && in_ready_o) begin
        moved = 1'b1;
        n_before = pending_entries.size();
        fold_kmer(drv.hash, drv.pos, drv.eos);
        // table rows carry their last result typed in by hand
        if (drv.typed) begin
          if (pending_entries.size() == n_before) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
              $display("table row with hash %h caused no result", drv.hash);
          end else begin
            want = pending_entries.pop_back();
            want.kind  = drv.t_kind;
            want.index = drv.t_index;
            want.len   = drv.t_len;
            pending_entries.push_back(want);
          end
        end
      end
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        got = mk_entry(result_kind_o, entry_hash_o, entry_position_o, list_index_o,
                       run_length_o);
        got.fin = final_result_o;
        if (pending_entries.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("result transfer with nothing pending at %0t", $realtime);
            report_entry("actual", got);
          end
        end else begin
          want = pending_entries.pop_front();
          if (got.kind != want.kind || got.hash != want.hash || got.pos != want.pos ||
              got.index != want.index || got.len != want.len || got.fin != want.fin) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX) begin
              $display("result mismatch at %0t", $realtime);
              report_entry("expected", want);
              report_entry("actual  ", got);
            end
          end
        end
      end
      if (moved) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // output side stalls on its own schedule
  initial begin : receiver
    rx_mode_e mode;
    int span;
    int period;
    int stall_len;
    int cnt;
    forever begin
      mode      = rx_mode_e'($urandom_range(0, 3));
      span      = $urandom_range(64, 256);
      period    = $urandom_range(3, 16);
      stall_len = $urandom_range(1, period - 1);
      for (cnt = 0; cnt < span; cnt++) begin
        @(negedge clk_i);
        case (mode)
          RX_OPEN:  out_ready_i <= 1'b1;
          RX_LIGHT: out_ready_i <= ($urandom_range(0, 3) != 0);
          RX_HEAVY: out_ready_i <= ($urandom_range(0, 9) < 3);
          default:  out_ready_i <= ((cnt % period) >= stall_len);
        endcase
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_kmer(input kmer_stim_t s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    drv        <= s;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_occ_limit(input logic [CFG_W-1:0] value);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic settle_outputs(input int extra);
    in_valid_i <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic kmer_stim_t table_row(input logic [HASH_W-1:0] hash,
                                           input logic [POS_W-1:0] pos, input logic eos,
                                           input logic typed, input logic [KIND_W-1:0] kind,
                                           input logic [POS_W-1:0] index,
                                           input logic [LEN_W-1:0] len);
    kmer_stim_t s;
    s.hash    = hash;
    s.pos     = pos;
    s.eos     = eos;
    s.typed   = typed;
    s.t_kind  = kind;
    s.t_index = index;
    s.t_len   = len;
    return s;
  endfunction

  // mostly ascending runs with random content, plus unsorted hops and early stream ends
  task automatic stream_runs(input logic [CFG_W-1:0] limit_now, input int n_items);
    int left;
    int len;
    int sel;
    int i;
    logic [HASH_W-1:0] h;
    logic [HASH_W-1:0] prev_h;
    logic [HASH_W-1:0] prev2_h;
    kmer_stim_t s;
    left    = n_items;
    h       = {$urandom, $urandom} >> $urandom_range(8, 63);
    prev_h  = h;
    prev2_h = h;
    while (left > 0) begin
      prev2_h = prev_h;
      prev_h  = h;
      sel = $urandom_range(0, 99);
      if (sel < 75) h = h + $urandom_range(1, 300);
      else if (sel < 88) h = h + ({$urandom, $urandom} >> $urandom_range(1, 40));
      else if (sel < 94) h = {$urandom, $urandom};
      else h = prev2_h;
      sel = $urandom_range(0, 99);
      if (sel < 65) len = $urandom_range(1, 4);
      else if (sel < 80) len = int'(limit_now) + $urandom_range(0, 2) - 1;
      else if (sel < 90) len = $urandom_range(5, 12);
      else len = $urandom_range(30, 36);
      if (len < 1) len = 1;
      if (len > left) len = left;
      for (i = 0; i < len; i++) begin
        s = '0;
        s.hash = h;
        sel = $urandom_range(0, 19);
        if (sel == 0) s.pos = '0;
        else if (sel == 1) s.pos = POS_ONES;
        else s.pos = POS_W'({$urandom, $urandom});
        s.eos = (left == 1) || ($urandom_range(0, 199) == 0);
        send_kmer(s);
        left--;
      end
    end
  endtask

  initial begin : stimulus
    kmer_stim_t directed_rows [DIRECTED_N];
    int phase_no;
    int random_items;
    int n;
    int k;
    logic [CFG_W-1:0] limit_now;

    // limit is at its reset value during the table
    directed_rows[0]  = table_row(64'h0, 40'h0, 1'b0, 1'b0, RES_POS, '0, '0);
    directed_rows[1]  = table_row(64'h0, POS_ONES, 1'b0, 1'b0, RES_POS, '0, '0);
    directed_rows[2]  = table_row(64'h1, 40'h55_5555_5555, 1'b0, 1'b1, RES_ENTRY, 40'd0, 6'd2);
    directed_rows[3]  = table_row(64'h1, 40'hAA_AAAA_AAAA, 1'b0, 1'b0, RES_POS, '0, '0);
    // hash goes down: unsorted input still closes the run
    directed_rows[4]  = table_row(64'h0, 40'h7, 1'b0, 1'b1, RES_ENTRY, 40'd2, 6'd2);
    // equal hash, not adjacent: separate run
    directed_rows[5]  = table_row(64'h1, 40'h9, 1'b0, 1'b1, RES_ENTRY, 40'd4, 6'd1);
    directed_rows[6]  = table_row('1, 40'h3, 1'b1, 1'b1, RES_END, 40'd7, 6'd0);
    // after the end marker the list index restarts at zero
    directed_rows[7]  = table_row(64'h0123_4567_89AB_CDEF, 40'h1, 1'b1, 1'b1, RES_END,
                                  40'd1, 6'd0);
    directed_rows[8]  = table_row(64'h2, 40'h0, 1'b0, 1'b0, RES_POS, '0, '0);
    directed_rows[9]  = table_row(64'h2, 40'h1, 1'b0, 1'b0, RES_POS, '0, '0);
    directed_rows[10] = table_row(64'h2, 40'h2, 1'b1, 1'b1, RES_END, 40'd3, 6'd0);
    directed_rows[11] = table_row(64'h8000_0000_0000_0000, 40'h80_0000_0000, 1'b1, 1'b1,
                                  RES_END, 40'd1, 6'd0);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (k = 0; k < DIRECTED_N; k++) send_kmer(directed_rows[k]);
    settle_outputs(SETTLE_CYCLES);

    phase_no     = 0;
    random_items = DIRECTED_N;
    while (random_items < ITEM_GOAL) begin
      case (phase_no)
        0:       limit_now = 6'd1;
        1:       limit_now = 6'd0;   // every run dropped, only end markers
        2:       limit_now = 6'd32;
        3:       limit_now = 6'd31;
        default: limit_now = CFG_W'($urandom_range(1, 32));
      endcase
      write_occ_limit(limit_now);
      n = (limit_now == 6'd0) ? 30 : $urandom_range(40, 80);
      if (n > ITEM_GOAL - random_items) n = ITEM_GOAL - random_items;
      stream_runs(limit_now, n);
      random_items += n;
      phase_no++;
      settle_outputs(SETTLE_CYCLES);
    end

    settle_outputs(DRAIN_CYCLES);
    if (mismatch_count == 0 && pending_entries.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
